[rtl/tphi_pkg.sv]
`default_nettype none
package tphi_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int TS_W       = 32;
  localparam int VAL_W      = 32;
  localparam int NUM_VAL    = 6;
  localparam int FRAC_W     = 16;
  localparam int ALPHA_W    = FRAC_W + 1;
  localparam int TAG_W      = $clog2(NUM_VAL);
  localparam int IN_DATA_W  = TS_W + NUM_VAL * VAL_W;
  localparam int OUT_DATA_W = NUM_VAL * VAL_W;

  localparam logic [TS_W-1:0] MAX_AGE_RST = 32'd1000000;

  // x, y, z, pitch, yaw, roll from index 0 up
  typedef logic [NUM_VAL-1:0][VAL_W-1:0] tphi_vals_t;

  // same layout as the input tdata: time in the low bits
  typedef struct packed {
    tphi_vals_t      vals;
    logic [TS_W-1:0] ts;
  } tphi_entry_t;

  typedef struct packed {
    logic             vld;
    logic [TAG_W-1:0] tag;
  } tphi_mix_ctl_t;

endpackage
`default_nettype wire

[rtl/tphi_store.sv]
`default_nettype none
module tphi_store #(
  parameter int DEPTH = tphi_pkg::HISTORY_DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [IDX_W-1:0]     wr_addr,
  input  wire tphi_pkg::tphi_entry_t wr_data,
  input  wire logic [IDX_W-1:0]     rd_addr,
  output tphi_pkg::tphi_entry_t      rd_data
);

  tphi_pkg::tphi_entry_t mem [DEPTH];
  tphi_pkg::tphi_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[rtl/tphi_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle: alpha = (num << 16) / den
// for num <= den, zero when den is zero.
module tphi_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [tphi_pkg::TS_W-1:0]      num,
  input  wire logic [tphi_pkg::TS_W-1:0]      den,
  output logic                                done,
  output logic [tphi_pkg::ALPHA_W-1:0]        alpha
);

  localparam int W     = tphi_pkg::TS_W;
  localparam int QW    = tphi_pkg::ALPHA_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W:0]       rem_r, rem_nxt;
  logic [W-1:0]     den_r, den_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic             zero_r, zero_nxt;
  logic [W+1:0]     diff;
  logic             ge;
  logic [W:0]       rem_sel;

  assign diff    = {1'b0, rem_r} - {2'b00, den_r};
  assign ge      = ~diff[W+1];
  assign rem_sel = ge ? diff[W:0] : rem_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    zero_nxt = zero_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QW);
      rem_nxt  = {1'b0, num};
      den_nxt  = den;
      q_nxt    = '0;
      zero_nxt = (den == '0);
    end else if (busy_r) begin
      // remainder stays below den, so the shift keeps it in range
      q_nxt   = {q_r[QW-2:0], ge};
      rem_nxt = {rem_sel[W-1:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    zero_r <= zero_nxt;
  end

  assign done  = done_r;
  assign alpha = zero_r ? '0 : q_r;

endmodule
`default_nettype wire

[rtl/tphi_mix.sv]
`default_nettype none
// Two-stage blend unit: y = a + floor((b - a) * alpha / 2^16).
module tphi_mix (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tphi_pkg::tphi_mix_ctl_t         ctl_in,
  input  wire logic [tphi_pkg::VAL_W-1:0]      a,
  input  wire logic [tphi_pkg::VAL_W-1:0]      b,
  input  wire logic [tphi_pkg::ALPHA_W-1:0]    alpha,
  output tphi_pkg::tphi_mix_ctl_t              ctl_out,
  output logic [tphi_pkg::VAL_W-1:0]           y
);

  localparam int VW     = tphi_pkg::VAL_W;
  localparam int PROD_W = VW + 1 + tphi_pkg::ALPHA_W + 1;

  logic signed [VW:0]       diff;
  logic signed [PROD_W-1:0] prod;

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [VW-1:0]            a_r, a_nxt;
  logic [VW-1:0]            y_r, y_nxt;
  tphi_pkg::tphi_mix_ctl_t  ctl1_r, ctl1_nxt;
  tphi_pkg::tphi_mix_ctl_t  ctl2_r, ctl2_nxt;

  assign diff = $signed({b[VW-1], b}) - $signed({a[VW-1], a});
  assign prod = diff * $signed({1'b0, alpha});

  always_comb begin
    prod_nxt = prod;
    a_nxt    = a;
    ctl1_nxt = ctl_in;
    // arithmetic shift floors both signs; the sum stays between a and b
    y_nxt    = a_r + prod_r[tphi_pkg::FRAC_W +: VW];
    ctl2_nxt = ctl1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl2_nxt;
    end
    prod_r <= prod_nxt;
    a_r    <= a_nxt;
    y_r    <= y_nxt;
  end

  assign ctl_out = ctl2_r;
  assign y       = y_r;

endmodule
`default_nettype wire

[rtl/timestamped_pose_history_interp.sv]
// Pose history for one tracked object: a ring of HISTORY_DEPTH timestamped
// snapshots (x, y, z, pitch, yaw, roll in Q16.16) in a single-port-read
// memory. A record transfer (tuser 0) appends a snapshot, overwriting the
// oldest when full, then drops entries from the oldest end while they are
// below its time minus max_age, keeping at least one; it returns nothing.
// A query transfer (tuser 1) returns one pose: the first snapshot if the
// time is at or before it, the last if at or after it, otherwise a linear
// blend between the first bracketing pair; found is 0 with all-zero data
// on an empty history. in_tready is low while an item is in work. A record
// writes, then reads and checks the oldest entry, again per dropped entry.
// A query on an empty history goes straight to the output; else it reads
// the first and last snapshots, and when it scans, the scan reads one
// memory entry per cycle, the serial divider computes alpha, and one shared
// multiply-add unit blends the six components. A query also holds in its
// output state while the previous result waits in the output register.
// A finished result waits in the output register while the next item is
// taken. max_age may be written on the cfg channel while the block is idle.
`default_nettype none
module timestamped_pose_history_interp #(
  parameter int HISTORY_DEPTH = tphi_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // time_stamp, pos_x, pos_y, pos_z, angle_pitch, angle_yaw, angle_roll
  input  wire logic [tphi_pkg::IN_DATA_W-1:0]     in_tdata,
  // req_type
  input  wire logic [0:0]                         in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // out_x, out_y, out_z, out_pitch, out_yaw, out_roll
  output logic [tphi_pkg::OUT_DATA_W-1:0]         out_tdata,
  // found
  output logic [0:0]                              out_tuser,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tphi_pkg::TS_W-1:0]          cfg_data
);

  localparam int IDX_W   = $clog2(HISTORY_DEPTH);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int TW      = tphi_pkg::TS_W;
  localparam int TAG_W   = tphi_pkg::TAG_W;
  localparam int NUM_VAL = tphi_pkg::NUM_VAL;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TRD    = 4'd1;
  localparam logic [3:0] S_TCHK   = 4'd2;
  localparam logic [3:0] S_QFIRST = 4'd3;
  localparam logic [3:0] S_QLAST  = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_MIX    = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  function automatic logic [IDX_W-1:0] inc_slot(input logic [IDX_W-1:0] s);
    inc_slot = (s == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] add_slot(input logic [IDX_W-1:0] s,
                                                input logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(s) + SUM_W'(n);
    if (sum >= SUM_W'(HISTORY_DEPTH)) begin
      sum = sum - SUM_W'(HISTORY_DEPTH);
    end
    add_slot = sum[IDX_W-1:0];
  endfunction

  logic [3:0]                     state_r, state_nxt;
  logic [IDX_W-1:0]               oldest_r, oldest_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [TW-1:0]                  max_age_r, max_age_nxt;
  logic [TW:0]                    limit_r, limit_nxt;
  logic [TW-1:0]                  qt_r, qt_nxt;
  tphi_pkg::tphi_entry_t          a_r, a_nxt;
  tphi_pkg::tphi_entry_t          b_r, b_nxt;
  logic [IDX_W-1:0]               p_r, p_nxt;
  logic [CNT_W-1:0]               k_r, k_nxt;
  logic [tphi_pkg::ALPHA_W-1:0]   alpha_r, alpha_nxt;
  logic [TAG_W-1:0]               c_r, c_nxt;
  tphi_pkg::tphi_vals_t           res_r, res_nxt;
  logic                           found_r, found_nxt;
  logic                           out_vld_r, out_vld_nxt;
  tphi_pkg::tphi_vals_t           out_data_r, out_data_nxt;
  logic                           out_found_r, out_found_nxt;

  tphi_pkg::tphi_entry_t          in_entry;
  logic                           in_xfer;
  logic                           is_query;
  logic                           full;
  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;
  logic [IDX_W-1:0]               rd_addr;
  tphi_pkg::tphi_entry_t          rd_data;
  logic                           drop;

  logic                           div_start;
  logic [TW-1:0]                  div_num;
  logic [TW-1:0]                  div_den;
  logic                           div_done;
  logic [tphi_pkg::ALPHA_W-1:0]   div_alpha;

  tphi_pkg::tphi_mix_ctl_t        mix_in;
  tphi_pkg::tphi_mix_ctl_t        mix_out;
  logic [tphi_pkg::VAL_W-1:0]     mix_a;
  logic [tphi_pkg::VAL_W-1:0]     mix_b;
  logic [tphi_pkg::VAL_W-1:0]     mix_y;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign in_entry  = tphi_pkg::tphi_entry_t'(in_tdata);
  assign is_query  = in_tuser[0];
  assign full      = (count_r == CNT_W'(HISTORY_DEPTH));
  assign cfg_ready = 1'b1;

  // when full, oldest + depth wraps back onto the oldest slot
  assign wr_en   = in_xfer & ~is_query;
  assign wr_addr = add_slot(oldest_r, count_r);

  assign drop = (count_r > CNT_W'(1)) && !limit_r[TW] && (rd_data.ts < limit_r[TW-1:0]);

  always_comb begin
    unique case (state_r)
      S_IDLE:   rd_addr = oldest_r;
      S_TRD:    rd_addr = oldest_r;
      S_TCHK:   rd_addr = inc_slot(oldest_r);
      S_QFIRST: rd_addr = add_slot(oldest_r, count_r - 1'b1);
      S_QLAST:  rd_addr = inc_slot(oldest_r);
      S_SCAN:   rd_addr = inc_slot(p_r);
      default:  rd_addr = oldest_r;
    endcase
  end

  tphi_store #(
    .DEPTH (HISTORY_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign div_num = qt_r - a_r.ts;
  assign div_den = rd_data.ts - a_r.ts;

  tphi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .alpha (div_alpha)
  );

  assign mix_in.vld = (state_r == S_MIX) && (c_r != TAG_W'(NUM_VAL));
  assign mix_in.tag = c_r;
  assign mix_a      = a_r.vals[c_r];
  assign mix_b      = b_r.vals[c_r];

  tphi_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (mix_in),
    .a       (mix_a),
    .b       (mix_b),
    .alpha   (alpha_r),
    .ctl_out (mix_out),
    .y       (mix_y)
  );

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    max_age_nxt   = max_age_r;
    limit_nxt     = limit_r;
    qt_nxt        = qt_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    p_nxt         = p_r;
    k_nxt         = k_r;
    alpha_nxt     = alpha_r;
    c_nxt         = '0;
    res_nxt       = res_r;
    found_nxt     = found_r;
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    out_found_nxt = out_found_r;
    div_start     = 1'b0;

    if (cfg_valid) begin
      max_age_nxt = cfg_data;
    end
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          qt_nxt = in_entry.ts;
          if (!is_query) begin
            if (full) begin
              oldest_nxt = inc_slot(oldest_r);
            end else begin
              count_nxt = count_r + 1'b1;
            end
            limit_nxt = {1'b0, in_entry.ts} - {1'b0, max_age_r};
            state_nxt = S_TRD;
          end else if (count_r == '0) begin
            found_nxt = 1'b0;
            res_nxt   = '0;
            state_nxt = S_OUT;
          end else begin
            found_nxt = 1'b1;
            state_nxt = S_QFIRST;
          end
        end
      end
      S_TRD: begin
        state_nxt = S_TCHK;
      end
      S_TCHK: begin
        // address already points at the next oldest, so stay and recheck
        if (drop) begin
          oldest_nxt = inc_slot(oldest_r);
          count_nxt  = count_r - 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_QFIRST: begin
        if (qt_r <= rd_data.ts) begin
          a_nxt     = rd_data;
          b_nxt     = rd_data;
          alpha_nxt = '0;
          state_nxt = S_MIX;
        end else begin
          a_nxt     = rd_data;
          state_nxt = S_QLAST;
        end
      end
      S_QLAST: begin
        if (qt_r >= rd_data.ts) begin
          a_nxt     = rd_data;
          b_nxt     = rd_data;
          alpha_nxt = '0;
          state_nxt = S_MIX;
        end else begin
          p_nxt     = inc_slot(oldest_r);
          k_nxt     = CNT_W'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (qt_r >= a_r.ts && qt_r <= rd_data.ts) begin
          b_nxt     = rd_data;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else if (k_r == count_r - 1'b1) begin
          // no pair brackets the time: fall back to the newest
          a_nxt     = rd_data;
          b_nxt     = rd_data;
          alpha_nxt = '0;
          state_nxt = S_MIX;
        end else begin
          a_nxt = rd_data;
          p_nxt = inc_slot(p_r);
          k_nxt = k_r + 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          alpha_nxt = div_alpha;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        c_nxt = mix_in.vld ? c_r + 1'b1 : c_r;
        if (mix_out.vld) begin
          res_nxt[mix_out.tag] = mix_y;
          if (mix_out.tag == TAG_W'(NUM_VAL - 1)) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt   = 1'b1;
          out_data_nxt  = res_r;
          out_found_nxt = found_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      oldest_r  <= '0;
      count_r   <= '0;
      max_age_r <= tphi_pkg::MAX_AGE_RST;
      c_r       <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      oldest_r  <= oldest_nxt;
      count_r   <= count_nxt;
      max_age_r <= max_age_nxt;
      c_r       <= c_nxt;
      out_vld_r <= out_vld_nxt;
    end
    limit_r     <= limit_nxt;
    qt_r        <= qt_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    p_r         <= p_nxt;
    k_r         <= k_nxt;
    alpha_r     <= alpha_nxt;
    res_r       <= res_nxt;
    found_r     <= found_nxt;
    out_data_r  <= out_data_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

endmodule
`default_nettype wire

[rtl/tphi_chk.sv]
`default_nettype none
module tphi_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic [0:0]                         in_tuser,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [tphi_pkg::OUT_DATA_W-1:0]    out_tdata,
  input wire logic [0:0]                         out_tuser
);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous still in work");

  // record writes, then reads back the oldest before it can finish
  a_record_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[0] |=> !in_tready ##1 !in_tready)
    else $error("record finished too early");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("not-found result carries data");

  a_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a query in work");

endmodule

bind timestamped_pose_history_interp tphi_chk u_tphi_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import tphi_pkg::*;

  localparam int HIST_DEPTH     = HISTORY_DEPTH_DEF;
  localparam int QUIET_CYCLES   = 150;
  localparam int DRAIN_CYCLES   = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int STEADY_FROM    = 300;
  localparam int STEADY_TO      = 420;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef enum logic {STIM_ITEM, STIM_CFG} stim_kind_t;

  typedef struct {
    stim_kind_t      kind;
    logic            req;
    logic [TS_W-1:0] stamp;
    tphi_vals_t      vals;
    logic [TS_W-1:0] cfg_word;
  } stim_t;

  typedef struct {
    logic       found;
    tphi_vals_t vals;
  } pose_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [0:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [TS_W-1:0]       cfg_data   = '0;

  timestamped_pose_history_interp dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial forever #2 clk = ~clk;

  // Predicted history ring and register
  logic [TS_W-1:0] hist_time [HIST_DEPTH];
  tphi_vals_t      hist_vals [HIST_DEPTH];
  int unsigned     hist_oldest   = 0;
  int unsigned     hist_count    = 0;
  logic [TS_W-1:0] age_limit_reg = MAX_AGE_RST;

  stim_t       pending_items [$];
  pose_t       expected_poses [$];
  int          fail_count   = 0;
  int          accepted     = 0;
  int          quiet        = 0;
  int          stall_cycles = 0;
  logic [TS_W-1:0] gen_time;
  tphi_vals_t  walk_vals = '0;

  string pose_field [NUM_VAL] = '{"out_x", "out_y", "out_z", "out_pitch", "out_yaw", "out_roll"};

  function automatic pose_t blend_pair(int unsigned sa, int unsigned sb, longint alpha);
    pose_t  r;
    longint a, b, p;
    r.found = 1'b1;
    for (int i = 0; i < NUM_VAL; i++) begin
      a = longint'($signed(hist_vals[sa][i]));
      b = longint'($signed(hist_vals[sb][i]));
      p = (b - a) * alpha;
      r.vals[i] = 32'(a + (p >>> FRAC_W));
    end
    return r;
  endfunction

  function automatic pose_t lookup_pose(logic [TS_W-1:0] t);
    pose_t           r;
    int unsigned     first, last, sa, sb;
    logic [TS_W-1:0] ta, tb, dt, span;
    logic [47:0]     frac;
    longint          alpha;
    r.found = 1'b0;
    r.vals  = '0;
    if (hist_count == 0) return r;
    first = hist_oldest;
    last  = (hist_oldest + hist_count - 1) % HIST_DEPTH;
    if (t <= hist_time[first]) return blend_pair(first, first, 0);
    if (t >= hist_time[last]) return blend_pair(last, last, 0);
    for (int k = 0; k + 1 < hist_count; k++) begin
      sa = (hist_oldest + k) % HIST_DEPTH;
      sb = (hist_oldest + k + 1) % HIST_DEPTH;
      ta = hist_time[sa];
      tb = hist_time[sb];
      if (t >= ta && t <= tb) begin
        dt    = t - ta;
        span  = tb - ta;
        alpha = 0;
        if (span != 0) begin
          frac = {dt, 16'd0} / {16'd0, span};
          if (frac > 48'd65536) frac = 48'd65536;
          alpha = longint'(frac);
        end
        return blend_pair(sa, sb, alpha);
      end
    end
    return blend_pair(last, last, 0);
  endfunction

  task automatic store_snapshot(logic [TS_W-1:0] t, tphi_vals_t v);
    int unsigned s;
    longint      lim;
    if (hist_count >= HIST_DEPTH) begin
      // full: the new snapshot takes the oldest slot
      hist_oldest = (hist_oldest + 1) % HIST_DEPTH;
      s = (hist_oldest + HIST_DEPTH - 1) % HIST_DEPTH;
    end else begin
      s = (hist_oldest + hist_count) % HIST_DEPTH;
      hist_count++;
    end
    hist_time[s] = t;
    hist_vals[s] = v;
    lim = longint'({32'd0, t}) - longint'({32'd0, age_limit_reg});
    while (hist_count > 1 && longint'({32'd0, hist_time[hist_oldest]}) < lim) begin
      hist_oldest = (hist_oldest + 1) % HIST_DEPTH;
      hist_count--;
    end
  endtask

  function automatic bit take_break();
    if (accepted >= STEADY_FROM && accepted < STEADY_TO) return 1'b0;
    return $urandom_range(0, 99) < 13;
  endfunction

  // Stimulus building
  function automatic tphi_vals_t same_vals(logic [VAL_W-1:0] v);
    return {NUM_VAL{v}};
  endfunction

  function automatic tphi_vals_t next_vals();
    for (int i = 0; i < NUM_VAL; i++) begin
      case ($urandom_range(0, 9))
        6, 7:    walk_vals[i] = $urandom;
        8:       walk_vals[i] = 32'h8000_0000;
        9:       walk_vals[i] = 32'h7FFF_FFFF;
        default: walk_vals[i] = walk_vals[i] + 32'($urandom_range(0, 2000)) - 32'd1000;
      endcase
    end
    return walk_vals;
  endfunction

  task automatic push_item(logic req, logic [TS_W-1:0] t, tphi_vals_t v);
    stim_t s;
    s.kind     = STIM_ITEM;
    s.req      = req;
    s.stamp    = t;
    s.vals     = v;
    s.cfg_word = '0;
    pending_items.push_back(s);
  endtask

  task automatic push_cfg(logic [TS_W-1:0] w);
    stim_t s;
    s.kind     = STIM_CFG;
    s.req      = REQ_RECORD;
    s.stamp    = '0;
    s.vals     = '0;
    s.cfg_word = w;
    pending_items.push_back(s);
  endtask

  // Records mostly moving forward in time, queries mostly at or behind the
  // latest record time, plus out-of-order records and stray query times.
  task automatic gen_phase(int n, int rec_pct, int unsigned step);
    logic [TS_W-1:0] t;
    int              r;
    gen_time = $urandom;
    repeat (n) begin
      if ($urandom_range(0, 99) < rec_pct) begin
        r = $urandom_range(0, 99);
        if (r < 88) begin
          t = gen_time + $urandom_range(0, step);
          gen_time = t;
        end else if (r < 97) begin
          t = gen_time - $urandom_range(0, 3 * step);
        end else begin
          t = $urandom;
        end
        push_item(REQ_RECORD, t, next_vals());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70)      t = gen_time - $urandom_range(0, 20 * step);
        else if (r < 85) t = gen_time + $urandom_range(0, step);
        else if (r < 95) t = $urandom;
        else             t = gen_time;
        push_item(REQ_QUERY, t, next_vals());
      end
    end
  endtask

  task automatic build_stimulus();
    // empty history
    push_item(REQ_QUERY, 32'h0000_0000, same_vals(32'h0));
    push_item(REQ_QUERY, 32'hFFFF_FFFF, same_vals(32'hFFFF_FFFF));
    // single entry, then equal timestamps
    push_item(REQ_RECORD, 32'd1000, same_vals(32'h8000_0000));
    push_item(REQ_QUERY, 32'd1000, same_vals(32'h0));
    push_item(REQ_RECORD, 32'd1000, same_vals(32'h7FFF_FFFF));
    push_item(REQ_QUERY, 32'd1000, same_vals(32'h0));
    // widest blend, both directions
    push_item(REQ_RECORD, 32'd3000, same_vals(32'h8000_0000));
    push_item(REQ_QUERY, 32'd2000, same_vals(32'h0));
    push_item(REQ_QUERY, 32'd2999, same_vals(32'h0));
    push_item(REQ_QUERY, 32'd1001, same_vals(32'h0));
    push_item(REQ_QUERY, 32'd500, same_vals(32'h0));
    push_item(REQ_QUERY, 32'd5000, same_vals(32'h0));
    // out-of-order record
    push_item(REQ_RECORD, 32'd2000, same_vals(32'h1234_5678));
    push_item(REQ_QUERY, 32'd1500, same_vals(32'h0));
    push_item(REQ_QUERY, 32'd2600, same_vals(32'h0));
    // trim limit below zero keeps everything
    push_item(REQ_RECORD, 32'd0, same_vals(32'h0));
    push_item(REQ_QUERY, 32'd2500, same_vals(32'h0));
    // far future record drops all older snapshots but itself
    push_item(REQ_RECORD, 32'hFFFF_FFFF, same_vals(32'hFFFF_FFFF));
    push_item(REQ_QUERY, 32'd0, same_vals(32'h0));
    push_item(REQ_RECORD, 32'hFFFF_FFFF - 32'd500000, same_vals(32'h0001_0000));
    push_item(REQ_RECORD, 32'hFFFF_FFFF, same_vals(32'hFFFE_0000));
    push_item(REQ_QUERY, 32'hFFFF_FFFF - 32'd250000, same_vals(32'h0));
    push_item(REQ_QUERY, 32'hFFFF_FFFF, same_vals(32'h0));

    push_cfg(32'hFFFF_FFFF);
    gen_phase(150, 75, 30000);
    push_cfg(32'd0);
    gen_phase(80, 50, 5);
    push_cfg($urandom_range(1000, 100000));
    gen_phase(150, 55, 33333);
    push_cfg($urandom);
    gen_phase(110, 50, $urandom_range(1, 1 << 20));
    push_cfg(32'd1);
    gen_phase(80, 50, 2);
    push_cfg(32'hFFFF_FFFF);
    gen_phase(80, 40, 3);
  endtask

  // Driver: one item or register write in flight at a time
  always @(posedge clk) begin : driver
    logic        in_v, cfg_v;
    stim_t       nxt;
    tphi_entry_t taken;
    in_v  = in_tvalid;
    cfg_v = cfg_valid;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        accepted++;
        taken = tphi_entry_t'(in_tdata);
        if (in_tuser[0] == REQ_QUERY) expected_poses.push_back(lookup_pose(taken.ts));
        else store_snapshot(taken.ts, taken.vals);
        in_v = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        age_limit_reg = cfg_data;
        cfg_v = 1'b0;
      end
      if (!in_v && !cfg_v && pending_items.size() > 0) begin
        if (pending_items[0].kind == STIM_CFG) begin
          // hold the write until the block has drained
          if (expected_poses.size() == 0) quiet++;
          else quiet = 0;
          if (quiet >= QUIET_CYCLES) begin
            nxt = pending_items.pop_front();
            cfg_data <= nxt.cfg_word;
            cfg_v = 1'b1;
            quiet = 0;
          end
        end else if (!take_break()) begin
          nxt = pending_items.pop_front();
          in_tuser <= nxt.req;
          in_tdata <= {nxt.vals, nxt.stamp};
          in_v = 1'b1;
        end
      end
    end
    in_tvalid <= in_v;
    cfg_valid <= cfg_v;
  end

  // Monitor: compare each result transfer with the oldest predicted pose
  always @(posedge clk) begin : monitor
    pose_t      want;
    tphi_vals_t got;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_poses.size() == 0) begin
        $error("unexpected result transfer: found %0d data %h", out_tuser[0], out_tdata);
        fail_count++;
      end else begin
        want = expected_poses.pop_front();
        got  = out_tdata;
        if (out_tuser[0] !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_tuser[0]);
          fail_count++;
        end
        for (int i = 0; i < NUM_VAL; i++) begin
          if (got[i] !== want.vals[i]) begin
            $error("%s: expected %h, got %h", pose_field[i], want.vals[i], got[i]);
            fail_count++;
          end
        end
      end
    end
    out_tready <= !take_break();
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles < WATCHDOG_LIMIT) begin
      stall_cycles <= stall_cycles + 1;
    end else begin
      $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() != 0 || in_tvalid || cfg_valid || expected_poses.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_poses.size() != 0) begin
      $error("%0d predicted poses never arrived", expected_poses.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tphi_pkg.sv
rtl/tphi_store.sv
rtl/tphi_div.sv
rtl/tphi_mix.sv
rtl/timestamped_pose_history_interp.sv
rtl/tphi_chk.sv
tb/testbench.sv
